### src/psfs_pkg.sv
package psfs_pkg;

    // Frame identifiers
    localparam int unsigned ID_W = 11;
    localparam logic [ID_W-1:0] ID_TRACTION    = 11'h153;
    localparam logic [ID_W-1:0] ID_GEAR        = 11'h43F;
    localparam logic [ID_W-1:0] ID_STEER       = 11'h1D2;
    localparam logic [ID_W-1:0] ID_WHEEL_FRONT = 11'h1F0;
    localparam logic [ID_W-1:0] ID_WHEEL_REAR  = 11'h1F5;

    localparam int unsigned DATA_W = 64;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_TABLE  = 2'd1;

    // Enable mask bits
    localparam int unsigned EN_TRACTION = 0;
    localparam int unsigned EN_GEAR     = 1;
    localparam int unsigned EN_STEER    = 2;
    localparam int unsigned EN_WHEEL    = 3;

    // Frame kinds, in emission order; also bit positions of the pending vector
    localparam int unsigned KIND_W = 3;
    localparam int unsigned NUM_KINDS = 5;
    localparam logic [KIND_W-1:0] KIND_TRACTION = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GEAR     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STEER    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FRONT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REAR     = 3'd4;

    localparam logic [3:0] PHASE_LAST = 4'd9;

    localparam logic [7:0] STEER_TAIL = 8'h03;

    // One tick snapshot, held while its frames drain
    typedef struct packed {
        logic [3:0]         status_flags;
        logic               sport_mode;
        logic [3:0]         gear_select;
        logic signed [15:0] steering_angle;
        logic signed [12:0] steering_rate;
        logic [15:0]        speed_front_left;
        logic [15:0]        speed_front_right;
        logic [15:0]        speed_rear_left;
        logic [15:0]        speed_rear_right;
        logic [7:0]         rolling_count;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_frame;

    // floor(v * 16 / 10) = floor(8v / 5); reciprocal of 5 scaled by 2^22 is exact
    // for every 19-bit numerator. Keep the low 16 bits of the quotient.
    function automatic logic [15:0] wheel_scale(input logic [15:0] v);
        logic [18:0] num;
        logic [38:0] prod;
        num  = {v, 3'b000};
        prod = 39'(num) * 39'(20'd838861);
        return prod[37:22];
    endfunction

endpackage

### src/psfs_if.sv
interface psfs_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         status_flags;
    logic               sport_mode;
    logic [3:0]         gear_select;
    logic signed [15:0] steering_angle;
    logic signed [12:0] steering_rate;
    logic [15:0]        speed_front_left;
    logic [15:0]        speed_front_right;
    logic [15:0]        speed_rear_left;
    logic [15:0]        speed_rear_right;

    modport source (
        output valid, status_flags, sport_mode, gear_select, steering_angle,
               steering_rate, speed_front_left, speed_front_right,
               speed_rear_left, speed_rear_right,
        input  ready
    );
    modport sink (
        input  valid, status_flags, sport_mode, gear_select, steering_angle,
               steering_rate, speed_front_left, speed_front_right,
               speed_rear_left, speed_rear_right,
        output ready
    );
endinterface

interface psfs_out_if;
    logic                         valid;
    logic                         ready;
    logic [psfs_pkg::ID_W-1:0]    frame_id;
    logic [psfs_pkg::DATA_W-1:0]  frame_data;
    logic                         last_frame;

    modport source (output valid, frame_id, frame_data, last_frame, input ready);
    modport sink   (input valid, frame_id, frame_data, last_frame, output ready);
    modport mon    (input valid, ready, frame_id, frame_data, last_frame);
endinterface

interface psfs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psfs_pkg::CFG_IDX_W-1:0] index;
    logic [psfs_pkg::DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/psfs_frame_build.sv
// Pack one frame of the held tick snapshot.
module psfs_frame_build (
    input  psfs_pkg::t_item                 i_item,
    input  logic [psfs_pkg::KIND_W-1:0]     i_kind,
    input  logic [psfs_pkg::DATA_W-1:0]     i_gear_table,
    output psfs_pkg::t_frame                o_frame
);

    logic [2:0]         gear_sel;
    logic [7:0]         gear_code;
    logic signed [10:0] ang_clamped;
    logic signed [15:0] ang_ext;
    logic signed [15:0] ang_x10;
    logic signed [16:0] rate_ext;
    logic signed [16:0] rate_x10;
    logic [15:0]        rate_sat;
    logic [15:0]        wheel_a;
    logic [15:0]        wheel_b;

    // Gear select above 7 falls back to neutral
    assign gear_sel  = i_item.gear_select[3] ? 3'd0 : i_item.gear_select[2:0];
    assign gear_code = i_gear_table[{gear_sel, 3'b000} +: 8];

    always_comb begin
        if (i_item.steering_angle > 16'sd720) begin
            ang_clamped = 11'sd720;
        end else if (i_item.steering_angle < -16'sd720) begin
            ang_clamped = -11'sd720;
        end else begin
            ang_clamped = i_item.steering_angle[10:0];
        end
    end

    assign ang_ext  = 16'(ang_clamped);
    assign ang_x10  = (ang_ext <<< 3) + (ang_ext <<< 1);

    assign rate_ext = 17'(i_item.steering_rate);
    assign rate_x10 = (rate_ext <<< 3) + (rate_ext <<< 1);

    always_comb begin
        if (rate_x10 > 17'sd32767) begin
            rate_sat = 16'h7FFF;
        end else if (rate_x10 < -17'sd32768) begin
            rate_sat = 16'h8000;
        end else begin
            rate_sat = rate_x10[15:0];
        end
    end

    // Share the two scalers between front and rear frames
    assign wheel_a = psfs_pkg::wheel_scale((i_kind == psfs_pkg::KIND_REAR) ?
                                           i_item.speed_rear_left :
                                           i_item.speed_front_left);
    assign wheel_b = psfs_pkg::wheel_scale((i_kind == psfs_pkg::KIND_REAR) ?
                                           i_item.speed_rear_right :
                                           i_item.speed_front_right);

    always_comb begin
        o_frame = '0;
        case (i_kind)
            psfs_pkg::KIND_TRACTION: begin
                o_frame.id   = psfs_pkg::ID_TRACTION;
                o_frame.data = {48'd0, i_item.rolling_count, 4'd0, i_item.status_flags};
            end
            psfs_pkg::KIND_GEAR: begin
                o_frame.id   = psfs_pkg::ID_GEAR;
                o_frame.data = {32'd0, i_item.rolling_count, gear_code,
                                7'd0, i_item.sport_mode, gear_code};
            end
            psfs_pkg::KIND_STEER: begin
                o_frame.id   = psfs_pkg::ID_STEER;
                o_frame.data = {24'd0, psfs_pkg::STEER_TAIL, rate_sat, ang_x10};
            end
            psfs_pkg::KIND_FRONT: begin
                o_frame.id   = psfs_pkg::ID_WHEEL_FRONT;
                o_frame.data = {32'd0, wheel_b, wheel_a};
            end
            psfs_pkg::KIND_REAR: begin
                o_frame.id   = psfs_pkg::ID_WHEEL_REAR;
                o_frame.data = {32'd0, wheel_b, wheel_a};
            end
            default: begin
                o_frame = '0;
            end
        endcase
    end

endmodule

### src/periodic_status_frame_scheduler.sv
// Channel   Dir  Modport  Transaction
// i_in      in   sink     one 50 Hz tick: status, gear, steering, four wheel speeds
// o_out     out  source   one CAN frame: frame_id, frame_data, last_frame
// i_cfg     in   sink     one register write: index, data (0 enable_mask, 1 gear table)
//
// A tick yields zero to four frames, one per cycle into the output register while o_out is
// not stalled; the tick is held in the item register and each frame is then registered into
// the output register. The next tick is taken in the cycle its predecessor's last frame
// moves into the output register; a tick that owes no frames is not held.
// Reset (i_rst_n low, synchronous) clears phase, rolling count, config registers and valid flags.
// A stall on o_out holds the frame and any tick still owing frames, and i_in waits for
// that tick's last frame to move. Config writes are always taken.
module periodic_status_frame_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psfs_in_if.sink    i_in,
    psfs_out_if.source o_out,
    psfs_cfg_if.sink   i_cfg
);

    // Configuration registers
    logic [3:0]                      r_enable;
    logic [psfs_pkg::DATA_W-1:0]     r_gear_table;

    // Tick state
    logic [3:0]                      r_phase;
    logic [7:0]                      r_count;
    logic [3:0]                      n_phase;
    logic [7:0]                      n_count;

    // Held tick and the frames it still owes
    logic                            r_item_valid;
    psfs_pkg::t_item                 r_item;
    logic [psfs_pkg::NUM_KINDS-1:0]  r_pend;
    logic [psfs_pkg::NUM_KINDS-1:0]  n_pend;
    logic [psfs_pkg::NUM_KINDS-1:0]  pend_rest;
    logic [psfs_pkg::KIND_W-1:0]     kind;
    logic                            last;

    // Output register
    logic                            r_out_valid;
    psfs_pkg::t_frame                r_frame;
    logic                            r_last;
    psfs_pkg::t_frame                frame;

    logic                            in_acc;
    logic                            cfg_acc;
    logic                            out_free;
    logic                            adv;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid & i_cfg.ready;

    // Phase and count advance on every accepted tick, frames or not
    assign n_phase = (r_phase == psfs_pkg::PHASE_LAST) ? 4'd0 : r_phase + 4'd1;
    assign n_count = r_count + 8'd1;

    // Frames owed by the incoming tick, in emission order
    always_comb begin
        n_pend = '0;
        n_pend[psfs_pkg::KIND_TRACTION] = r_enable[psfs_pkg::EN_TRACTION] &
                                          ((n_phase == 4'd0) | (n_phase == 4'd5));
        n_pend[psfs_pkg::KIND_GEAR]     = r_enable[psfs_pkg::EN_GEAR] &
                                          ((n_phase == 4'd1) | (n_phase == 4'd6));
        n_pend[psfs_pkg::KIND_STEER]    = r_enable[psfs_pkg::EN_STEER];
        n_pend[psfs_pkg::KIND_FRONT]    = r_enable[psfs_pkg::EN_WHEEL] & ~n_phase[0];
        n_pend[psfs_pkg::KIND_REAR]     = r_enable[psfs_pkg::EN_WHEEL] & ~n_phase[0];
    end

    // Pick the earliest owed frame
    always_comb begin
        kind = '0;
        for (int k = psfs_pkg::NUM_KINDS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                kind = psfs_pkg::KIND_W'(k);
            end
        end
    end

    assign pend_rest = r_pend & ~(psfs_pkg::NUM_KINDS'(1) << kind);
    assign last      = (pend_rest == '0);

    // Move a frame whenever the output register is empty or being emptied
    assign out_free   = ~r_out_valid | o_out.ready;
    assign adv        = r_item_valid & out_free;
    assign i_in.ready = ~r_item_valid | (adv & last);
    assign in_acc     = i_in.valid & i_in.ready;

    psfs_frame_build u_build (
        .i_item       (r_item),
        .i_kind       (kind),
        .i_gear_table (r_gear_table),
        .o_frame      (frame)
    );

    // Config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= '0;
            r_gear_table <= '0;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                psfs_pkg::CFG_ENABLE_MASK: r_enable     <= i_cfg.data[3:0];
                psfs_pkg::CFG_GEAR_TABLE:  r_gear_table <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Tick state and held item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_count      <= '0;
            r_item_valid <= 1'b0;
            r_pend       <= '0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_item_valid <= |n_pend;
            r_pend       <= n_pend;
        end else if (adv) begin
            r_pend <= pend_rest;
            if (last) begin
                r_item_valid <= 1'b0;
            end
        end
    end

    // Held item payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.status_flags      <= i_in.status_flags;
            r_item.sport_mode        <= i_in.sport_mode;
            r_item.gear_select       <= i_in.gear_select;
            r_item.steering_angle    <= i_in.steering_angle;
            r_item.steering_rate     <= i_in.steering_rate;
            r_item.speed_front_left  <= i_in.speed_front_left;
            r_item.speed_front_right <= i_in.speed_front_right;
            r_item.speed_rear_left   <= i_in.speed_rear_left;
            r_item.speed_rear_right  <= i_in.speed_rear_right;
            r_item.rolling_count     <= n_count;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_frame <= frame;
            r_last  <= last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_id   = r_frame.id;
    assign o_out.frame_data = r_frame.data;
    assign o_out.last_frame = r_last;

endmodule

### src/psfs_checker.sv
module psfs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ready,
    input  logic [psfs_pkg::ID_W-1:0]     i_frame_id,
    input  logic [psfs_pkg::DATA_W-1:0]   i_frame_data,
    input  logic                          i_last_frame
);

    // Output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("frame valid right after reset");

    // Stalled frame holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_frame_id)
            && $stable(i_frame_data) && $stable(i_last_frame))
        else $error("stalled frame changed");

    // Only known identifiers go out
    a_known_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_frame_id == psfs_pkg::ID_TRACTION)
            || (i_frame_id == psfs_pkg::ID_GEAR)
            || (i_frame_id == psfs_pkg::ID_STEER)
            || (i_frame_id == psfs_pkg::ID_WHEEL_FRONT)
            || (i_frame_id == psfs_pkg::ID_WHEEL_REAR))
        else $error("unknown frame id");

    // Front wheel frame is never marked last, since the rear one of the same tick follows
    a_front_then_rear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_frame_id == psfs_pkg::ID_WHEEL_FRONT)
            |-> !i_last_frame)
        else $error("front wheel frame marked last");

    // Gear code appears twice in the gear frame
    a_gear_code_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_frame_id == psfs_pkg::ID_GEAR)
            |-> (i_frame_data[7:0] == i_frame_data[23:16]))
        else $error("gear code bytes differ");

endmodule

bind periodic_status_frame_scheduler psfs_checker u_psfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_frame_id   (o_out.frame_id),
    .i_frame_data (o_out.frame_data),
    .i_last_frame (o_out.last_frame)
);
